/* sv/horspool_substring_search_top_defines.svh */
// Assertion macros shared by the checker of the substring search block.
`ifndef HORSPOOL_SUBSTRING_SEARCH_TOP_DEFINES_SVH
`define HORSPOOL_SUBSTRING_SEARCH_TOP_DEFINES_SVH

// Overlapping implication, disabled while reset is asserted.
`define HSS_ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("horspool_substring_search: assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define HSS_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("horspool_substring_search: assertion failed");

`endif

/* sv/hss_pkg.sv */
// Package with constants, register codes and shared types of the substring search block.
package hss_pkg;

  localparam int unsigned MAX_PATTERN   = 32;
  localparam int unsigned ALPHABET_SIZE = 256;
  localparam int unsigned MAX_TEXT      = 65536;

  localparam int unsigned BYTE_W    = 8;
  localparam int unsigned LEN_W     = 6;
  localparam int unsigned START_W   = 16;
  localparam int unsigned DATA_W    = 64;
  localparam int unsigned NUM_REGS  = 5;
  localparam int unsigned PAT_REGS  = 4;
  localparam int unsigned PAT_BYTES = PAT_REGS * DATA_W / BYTE_W;
  localparam int unsigned ADDR_W    = $clog2(8 * NUM_REGS);
  localparam int unsigned IDX_W     = ADDR_W - 3;
  localparam int unsigned TAB_AW    = $clog2(ALPHABET_SIZE);
  // Positions and alignment ends reach MAX_TEXT plus one pattern length.
  localparam int unsigned POS_W     = $clog2(MAX_TEXT + MAX_PATTERN);

  typedef enum logic [IDX_W-1:0] {
    REG_LENGTH    = IDX_W'(0),
    REG_PATTERN_0 = IDX_W'(1),
    REG_PATTERN_1 = IDX_W'(2),
    REG_PATTERN_2 = IDX_W'(3),
    REG_PATTERN_3 = IDX_W'(4)
  } hss_reg_e;

  typedef enum logic {
    SWEEP_IDLE,
    SWEEP_RUN
  } hss_sweep_e;

  // Configuration as seen by the datapath.
  typedef struct packed {
    logic [PAT_BYTES-1:0][BYTE_W-1:0] pattern;
    logic [LEN_W-1:0]                 len;
    logic                             restart;
  } hss_cfg_t;

endpackage

/* sv/horspool_substring_search_top.sv */
// Top level of the streaming Boyer-Moore-Horspool substring search block.
//
// The text channel carries one word per byte: text_byte_i and last_byte_i,
// the latter marking the final byte of a text. The result channel carries one
// word per text: found_o, match_start_o and text_too_long_o. Both channels
// use valid and ready. The pattern is set through the APB-style port.
// A result is registered and shows in the cycle after the byte that decides it.
// Bytes are taken at one per cycle while no rebuild runs and no result is
// stalled; the skip lookup uses the registered read of the skip memory and is
// forwarded into the next alignment compare. Each write to the length or a
// pattern register starts a rebuild of the skip memory, one entry per cycle
// through its single write port; no text byte is taken meanwhile, and the current text is abandoned.
// After reset the pattern is empty, so every text matches at offset 0 on its
// first byte, and no rebuild runs. While the receiver stalls a pending
// result, no further text byte is taken.
module horspool_substring_search_top
  import hss_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [ADDR_W-1:0]  paddr,
  input  logic [DATA_W-1:0]  pwdata,
  output logic [DATA_W-1:0]  prdata,
  output logic               pready,
  input  logic               text_valid_i,
  output logic               text_ready_o,
  input  logic [BYTE_W-1:0]  text_byte_i,
  input  logic               last_byte_i,
  output logic               result_valid_o,
  input  logic               result_ready_i,
  output logic               found_o,
  output logic [START_W-1:0] match_start_o,
  output logic               text_too_long_o
);

  hss_cfg_t          cfg;
  logic              tab_busy;
  logic              skip_rd_en;
  logic [TAB_AW-1:0] skip_rd_addr;
  logic [LEN_W-1:0]  skip_rd_data;

  hss_cfg_regs u_cfg_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  hss_skip_table u_skip_table (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cfg_i     (cfg),
    .rd_en_i   (skip_rd_en),
    .rd_addr_i (skip_rd_addr),
    .rd_data_o (skip_rd_data),
    .busy_o    (tab_busy)
  );

  hss_matcher u_matcher (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_i           (cfg),
    .busy_i          (tab_busy),
    .text_valid_i    (text_valid_i),
    .text_ready_o    (text_ready_o),
    .text_byte_i     (text_byte_i),
    .last_byte_i     (last_byte_i),
    .result_valid_o  (result_valid_o),
    .result_ready_i  (result_ready_i),
    .found_o         (found_o),
    .match_start_o   (match_start_o),
    .text_too_long_o (text_too_long_o),
    .skip_rd_en_o    (skip_rd_en),
    .skip_rd_addr_o  (skip_rd_addr),
    .skip_rd_data_i  (skip_rd_data)
  );

endmodule

/* sv/hss_cfg_regs.sv */
// Configuration register file with its APB-style access port.
module hss_cfg_regs
  import hss_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0] pwdata,
  output logic [DATA_W-1:0] prdata,
  output logic              pready,
  output hss_cfg_t          cfg_o
);

  logic [LEN_W-1:0]               len_q, len_d;
  logic [PAT_REGS-1:0][DATA_W-1:0] pat_q, pat_d;
  logic                           restart_q, restart_d;
  logic [IDX_W-1:0]               idx;
  logic                           wr_en;

  assign pready = 1'b1;
  assign idx    = paddr[ADDR_W-1:3];
  assign wr_en  = psel & penable & pwrite;

  // Register writes; a write to a known register restarts the search.
  always_comb begin
    len_d     = len_q;
    pat_d     = pat_q;
    restart_d = 1'b0;
    if (wr_en) begin
      case (hss_reg_e'(idx))
        REG_LENGTH: begin
          len_d     = pwdata[LEN_W-1:0];
          restart_d = 1'b1;
        end
        REG_PATTERN_0: begin
          pat_d[0]  = pwdata;
          restart_d = 1'b1;
        end
        REG_PATTERN_1: begin
          pat_d[1]  = pwdata;
          restart_d = 1'b1;
        end
        REG_PATTERN_2: begin
          pat_d[2]  = pwdata;
          restart_d = 1'b1;
        end
        REG_PATTERN_3: begin
          pat_d[3]  = pwdata;
          restart_d = 1'b1;
        end
        default: begin
          restart_d = 1'b0;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      len_q     <= '0;
      pat_q     <= '0;
      restart_q <= 1'b0;
    end else begin
      len_q     <= len_d;
      pat_q     <= pat_d;
      restart_q <= restart_d;
    end
  end

  // Read data.
  always_comb begin
    case (hss_reg_e'(idx))
      REG_LENGTH:    prdata = DATA_W'(len_q);
      REG_PATTERN_0: prdata = pat_q[0];
      REG_PATTERN_1: prdata = pat_q[1];
      REG_PATTERN_2: prdata = pat_q[2];
      REG_PATTERN_3: prdata = pat_q[3];
      default:       prdata = '0;
    endcase
  end

  // The restart pulse trails the write so that it sees the new values.
  assign cfg_o.pattern = pat_q;
  assign cfg_o.len     = (len_q > LEN_W'(MAX_PATTERN)) ? LEN_W'(MAX_PATTERN) : len_q;
  assign cfg_o.restart = restart_q;

endmodule

/* sv/hss_skip_table.sv */
// Bad-character skip memory with its rebuild sweep.
module hss_skip_table
  import hss_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  hss_cfg_t          cfg_i,
  input  logic              rd_en_i,
  input  logic [TAB_AW-1:0] rd_addr_i,
  output logic [LEN_W-1:0]  rd_data_o,
  output logic              busy_o
);

  logic [LEN_W-1:0]  skip_mem_q [ALPHABET_SIZE];
  logic [LEN_W-1:0]  rd_data_q;
  hss_sweep_e        state_q, state_d;
  logic [TAB_AW-1:0] cnt_q, cnt_d;
  logic              wr_en;
  logic [LEN_W-1:0]  wr_data;

  // Sweep control: one entry per cycle after every configuration change.
  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    wr_en   = 1'b0;
    case (state_q)
      SWEEP_IDLE: begin
        if (cfg_i.restart) begin
          state_d = SWEEP_RUN;
          cnt_d   = '0;
        end
      end
      SWEEP_RUN: begin
        wr_en = 1'b1;
        cnt_d = cnt_q + TAB_AW'(1);
        if (cfg_i.restart) begin
          cnt_d = '0;
        end else if (cnt_q == TAB_AW'(ALPHABET_SIZE - 1)) begin
          state_d = SWEEP_IDLE;
        end
      end
      default: begin
        state_d = SWEEP_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= SWEEP_IDLE;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
    end
  end

  // Skip of the swept byte: distance from its last occurrence before the final
  // pattern byte to the pattern end, or the pattern length if it does not occur.
  always_comb begin
    wr_data = cfg_i.len;
    for (int i = 0; i < MAX_PATTERN - 1; i++) begin
      if ((LEN_W'(i) + LEN_W'(1) < cfg_i.len) && (cfg_i.pattern[i] == cnt_q)) begin
        wr_data = cfg_i.len - LEN_W'(i) - LEN_W'(1);
      end
    end
  end

  // Single write port for the sweep, registered read port for lookups.
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      skip_mem_q[cnt_q] <= wr_data;
    end
    if (rd_en_i) begin
      rd_data_q <= skip_mem_q[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;
  assign busy_o    = (state_q == SWEEP_RUN);

endmodule

/* sv/hss_matcher.sv */
// Text window, alignment tracking, compare and result register.
module hss_matcher
  import hss_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  hss_cfg_t           cfg_i,
  input  logic               busy_i,
  input  logic               text_valid_i,
  output logic               text_ready_o,
  input  logic [BYTE_W-1:0]  text_byte_i,
  input  logic               last_byte_i,
  output logic               result_valid_o,
  input  logic               result_ready_i,
  output logic               found_o,
  output logic [START_W-1:0] match_start_o,
  output logic               text_too_long_o,
  output logic               skip_rd_en_o,
  output logic [TAB_AW-1:0]  skip_rd_addr_o,
  input  logic [LEN_W-1:0]   skip_rd_data_i
);

  logic [MAX_PATTERN-1:0][BYTE_W-1:0] window_q, window_d, window_sh;
  logic [POS_W-1:0]   pos_q, pos_d;
  logic [POS_W-1:0]   end_q, end_d, end_eff;
  logic [POS_W-1:0]   pend_pos_q, pend_pos_d;
  logic               pend_q, pend_d;
  logic               given_q, given_d;
  logic               out_valid_q, out_valid_d;
  logic               out_found_q, out_found_d;
  logic [START_W-1:0] out_start_q, out_start_d;
  logic               out_long_q, out_long_d;
  logic               accept;
  logic               eq;
  logic               hit;
  logic               restart_text;
  logic [LEN_W-1:0]   m_minus1;
  logic [POS_W-1:0]   start_pos;

  assign text_ready_o   = ~busy_i & ~cfg_i.restart & (~out_valid_q | result_ready_i);
  assign accept         = text_valid_i & text_ready_o;
  assign skip_rd_en_o   = accept;
  assign skip_rd_addr_o = text_byte_i;
  assign m_minus1       = cfg_i.len - LEN_W'(1);
  assign start_pos      = pos_q - POS_W'(m_minus1);

  // Slot j holds the byte that lines up with pattern byte j; new bytes enter
  // at the slot of the final pattern byte and move toward slot 0.
  always_comb begin
    window_sh = {window_q[0], window_q[MAX_PATTERN-1:1]};
    for (int k = 0; k < MAX_PATTERN; k++) begin
      if (LEN_W'(k) == m_minus1) begin
        window_sh[k] = text_byte_i;
      end
    end
  end

  // Parallel compare of the aligned window with the pattern.
  always_comb begin
    eq = 1'b1;
    for (int j = 0; j < MAX_PATTERN; j++) begin
      if ((LEN_W'(j) < cfg_i.len) && (window_sh[j] != cfg_i.pattern[j])) begin
        eq = 1'b0;
      end
    end
  end

  // A skip looked up in the previous cycle is forwarded into the alignment end.
  assign end_eff = pend_q ? (pend_pos_q + POS_W'(skip_rd_data_i)) : end_q;

  // Per-byte search step.
  always_comb begin
    window_d     = window_q;
    pos_d        = pos_q;
    end_d        = end_eff;
    pend_d       = 1'b0;
    pend_pos_d   = pend_pos_q;
    given_d      = given_q;
    hit          = 1'b0;
    restart_text = 1'b0;
    out_valid_d  = out_valid_q & ~result_ready_i;
    out_found_d  = out_found_q;
    out_start_d  = out_start_q;
    out_long_d   = out_long_q;

    if (cfg_i.restart) begin
      restart_text = 1'b1;
    end else if (accept) begin
      if (given_q) begin
        restart_text = last_byte_i;
      end else if (pos_q >= POS_W'(MAX_TEXT)) begin
        // Overlong text: only the final byte gives a result.
        if (last_byte_i) begin
          out_valid_d  = 1'b1;
          out_found_d  = 1'b0;
          out_start_d  = '0;
          out_long_d   = 1'b1;
          restart_text = 1'b1;
        end
      end else begin
        window_d = window_sh;
        pos_d    = pos_q + POS_W'(1);
        if (cfg_i.len == '0) begin
          hit = 1'b1;
        end else if (pos_q == end_eff) begin
          if (eq) begin
            hit = 1'b1;
          end else begin
            pend_d     = 1'b1;
            pend_pos_d = pos_q;
          end
        end
        if (hit) begin
          out_valid_d = 1'b1;
          out_found_d = 1'b1;
          out_start_d = (cfg_i.len == '0) ? '0 : start_pos[START_W-1:0];
          out_long_d  = 1'b0;
          if (last_byte_i) begin
            restart_text = 1'b1;
          end else begin
            given_d = 1'b1;
          end
        end else if (last_byte_i) begin
          out_valid_d  = 1'b1;
          out_found_d  = 1'b0;
          out_start_d  = '0;
          out_long_d   = 1'b0;
          restart_text = 1'b1;
        end
      end
    end

    if (restart_text) begin
      pos_d   = '0;
      end_d   = (cfg_i.len == '0) ? '0 : POS_W'(m_minus1);
      given_d = 1'b0;
      pend_d  = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q       <= '0;
      end_q       <= '0;
      pend_q      <= 1'b0;
      given_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      pos_q       <= pos_d;
      end_q       <= end_d;
      pend_q      <= pend_d;
      given_q     <= given_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    window_q    <= window_d;
    pend_pos_q  <= pend_pos_d;
    out_found_q <= out_found_d;
    out_start_q <= out_start_d;
    out_long_q  <= out_long_d;
  end

  assign result_valid_o  = out_valid_q;
  assign found_o         = out_found_q;
  assign match_start_o   = out_start_q;
  assign text_too_long_o = out_long_q;

endmodule

/* sv/hss_checker.sv */
// Port-level checker of the substring search block and its bind.
`include "horspool_substring_search_top_defines.svh"

module hss_checker
  import hss_pkg::*;
(
  input logic               clk_i,
  input logic               rst_ni,
  input logic               psel,
  input logic               penable,
  input logic               pwrite,
  input logic [ADDR_W-1:0]  paddr,
  input logic               pready,
  input logic               text_ready_o,
  input logic               result_valid_o,
  input logic               result_ready_i,
  input logic               found_o,
  input logic [START_W-1:0] match_start_o,
  input logic               text_too_long_o
);

  // A stalled result word holds.
  `HSS_ASSERT_NEXT(a_result_hold, clk_i, rst_ni, result_valid_o && !result_ready_i, result_valid_o && $stable(found_o) && $stable(match_start_o) && $stable(text_too_long_o))

  // No text byte is taken while a result waits on a stalled receiver.
  `HSS_ASSERT_IMPL(a_no_overrun, clk_i, rst_ni, text_ready_o && result_valid_o, result_ready_i)

  // A write to the length or a pattern register blocks the text channel for the rebuild.
  `HSS_ASSERT_NEXT(a_cfg_blocks, clk_i, rst_ni, psel && penable && pwrite && pready && (paddr[ADDR_W-1:3] <= IDX_W'(NUM_REGS - 1)), !text_ready_o)

  // A not-found result carries offset zero.
  `HSS_ASSERT_IMPL(a_miss_zero, clk_i, rst_ni, result_valid_o && !found_o, match_start_o == '0)

  // Overlong texts never report a match.
  `HSS_ASSERT_IMPL(a_long_no_hit, clk_i, rst_ni, result_valid_o && text_too_long_o, !found_o)

endmodule

bind horspool_substring_search_top hss_checker u_hss_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .psel            (psel),
  .penable         (penable),
  .pwrite          (pwrite),
  .paddr           (paddr),
  .pready          (pready),
  .text_ready_o    (text_ready_o),
  .result_valid_o  (result_valid_o),
  .result_ready_i  (result_ready_i),
  .found_o         (found_o),
  .match_start_o   (match_start_o),
  .text_too_long_o (text_too_long_o)
);
